FILE: sv/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, constants and ring-index helpers for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned Depth  = 1024;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned DataW  = 32;
  localparam int unsigned CapW   = 11;
  localparam int unsigned ActW   = 3;
  localparam int unsigned CountW = 11;

  localparam logic [CapW-1:0]  CapReset = CapW'(1024);
  localparam logic [DataW-1:0] EmptyVal = '1;

  typedef enum logic [ActW-1:0] {
    ACT_QUERY      = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_REAR  = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_REAR   = 3'd4
  } act_e;

  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } st_e;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef struct packed {
    logic             we;
    addr_t            waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    addr_t            raddr;
  } mem_req_t;

  typedef struct packed {
    logic                    ok;
    logic signed [DataW-1:0] front_value;
    logic signed [DataW-1:0] rear_value;
    logic                    is_empty;
    logic                    is_full;
    logic [CountW-1:0]       count;
  } res_t;

  // base + off modulo Depth, off below Depth
  function automatic addr_t ring_add(addr_t base, cnt_t off);
    logic [CntW:0] s;
    s = (CntW+1)'(base) + (CntW+1)'(off);
    if (s >= (CntW+1)'(Depth)) begin
      s = s - (CntW+1)'(Depth);
    end
    return addr_t'(s);
  endfunction

  function automatic addr_t ring_dec(addr_t base);
    addr_t r;
    if (base == '0) begin
      r = addr_t'(Depth - 1);
    end else begin
      r = base - addr_t'(1);
    end
    return r;
  endfunction

endpackage

FILE: sv/bdq_if.sv
// ----------------------------------------------------------------------------
// bdq_if
// Valid/ready channels of the bounded deque: action, result and capacity.
// ----------------------------------------------------------------------------
interface bdq_act_if;
  logic                                 valid;
  logic                                 ready;
  logic [bdq_pkg::ActW-1:0]             action;
  logic signed [bdq_pkg::DataW-1:0]     value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface bdq_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 ok;
  logic signed [bdq_pkg::DataW-1:0]     front_value;
  logic signed [bdq_pkg::DataW-1:0]     rear_value;
  logic                                 is_empty;
  logic                                 is_full;
  logic [bdq_pkg::CountW-1:0]           count;

  modport source (output valid, ok, front_value, rear_value, is_empty, is_full, count,
                  input ready);
  modport sink   (input valid, ok, front_value, rear_value, is_empty, is_full, count,
                  output ready);
endinterface

interface bdq_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [bdq_pkg::CapW-1:0]             capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

FILE: sv/bdq_mem.sv
// ----------------------------------------------------------------------------
// bdq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdq_mem (
  input  logic                        clk_i,
  input  bdq_pkg::mem_req_t           req_i,
  output logic [bdq_pkg::DataW-1:0]   rd_data_o
);
  import bdq_pkg::*;

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/bounded_deque.sv
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of 32-bit values in a ring buffer with run-time capacity.
// ----------------------------------------------------------------------------
// Each action item yields one result item. Query, push and refused actions
// register their result directly; a pop that leaves at least one entry first
// passes through a fetch state, as the new front or rear entry is fetched
// from the single-port-read entry store before the result is issued.
// Front and rear values are held in registers, so only pops touch the read
// port. One action is in flight at a time; a new action is taken in the
// cycle its predecessor's result leaves. The capacity register is always
// ready; write it only while no action is in flight.
module bounded_deque (
  input  logic          clk_i,
  input  logic          rst_ni,
  bdq_act_if.sink       act_i,
  bdq_res_if.source     res_o,
  bdq_cfg_if.sink       cfg_i
);
  import bdq_pkg::*;

  st_e              st_q, st_d;
  addr_t            head_q, head_d;
  cnt_t             cnt_q, cnt_d;
  logic [DataW-1:0] front_q, front_d;
  logic [DataW-1:0] rear_q, rear_d;
  logic             fill_rear_q, fill_rear_d;
  logic [CapW-1:0]  cap_q;
  res_t             res_q, res_d;
  logic             res_valid_q, res_valid_d;

  mem_req_t         mreq;
  logic [DataW-1:0] rd_data;

  cnt_t             eff_cap;
  logic             in_fire, res_fire, need_fill;
  logic             push_ok, pop_ok;
  act_e             act;

  function automatic res_t make_res(logic ok, cnt_t cnt, logic [DataW-1:0] fv,
                                    logic [DataW-1:0] rv, cnt_t cap);
    res_t r;
    r.ok          = ok;
    r.front_value = (cnt == '0) ? EmptyVal : fv;
    r.rear_value  = (cnt == '0) ? EmptyVal : rv;
    r.is_empty    = (cnt == '0);
    r.is_full     = (cnt == cap);
    r.count       = CountW'(cnt);
    return r;
  endfunction

  bdq_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mreq),
    .rd_data_o (rd_data)
  );

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.capacity;
    end
  end

  always_comb begin
    if (32'(cap_q) > 32'(Depth)) begin
      eff_cap = CntW'(Depth);
    end else begin
      eff_cap = CntW'(cap_q);
    end
  end

  assign act         = act_e'(act_i.action);
  assign act_i.ready = (st_q == ST_IDLE) && (!res_valid_q || res_o.ready);
  assign in_fire     = act_i.valid && act_i.ready;
  assign res_fire    = res_valid_q && res_o.ready;
  assign push_ok     = (cnt_q < eff_cap);
  assign pop_ok      = (cnt_q != '0);
  assign need_fill   = in_fire && ((act == ACT_POP_FRONT) || (act == ACT_POP_REAR))
                       && (cnt_q > cnt_t'(1));

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (need_fill) begin
          st_d = ST_FILL;
        end
      end
      ST_FILL: begin
        st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    logic ok;
    ok          = 1'b1;
    head_d      = head_q;
    cnt_d       = cnt_q;
    front_d     = front_q;
    rear_d      = rear_q;
    fill_rear_d = fill_rear_q;
    mreq        = '0;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_fire;

    case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (act)
            ACT_QUERY: begin
              ok = 1'b1;
            end
            ACT_PUSH_FRONT: begin
              ok = push_ok;
              if (push_ok) begin
                head_d     = ring_dec(head_q);
                mreq.we    = 1'b1;
                mreq.waddr = ring_dec(head_q);
                mreq.wdata = act_i.value;
                cnt_d      = cnt_q + cnt_t'(1);
                front_d    = act_i.value;
                if (cnt_q == '0) begin
                  rear_d = act_i.value;
                end
              end
            end
            ACT_PUSH_REAR: begin
              ok = push_ok;
              if (push_ok) begin
                mreq.we    = 1'b1;
                mreq.waddr = ring_add(head_q, cnt_q);
                mreq.wdata = act_i.value;
                cnt_d      = cnt_q + cnt_t'(1);
                rear_d     = act_i.value;
                if (cnt_q == '0) begin
                  front_d = act_i.value;
                end
              end
            end
            ACT_POP_FRONT: begin
              ok = pop_ok;
              if (pop_ok) begin
                head_d      = ring_add(head_q, cnt_t'(1));
                cnt_d       = cnt_q - cnt_t'(1);
                mreq.re     = 1'b1;
                mreq.raddr  = ring_add(head_q, cnt_t'(1));
                fill_rear_d = 1'b0;
              end
            end
            ACT_POP_REAR: begin
              ok = pop_ok;
              if (pop_ok) begin
                cnt_d       = cnt_q - cnt_t'(1);
                mreq.re     = 1'b1;
                mreq.raddr  = ring_add(head_q, cnt_q - cnt_t'(2));
                fill_rear_d = 1'b1;
              end
            end
            default: begin
              ok = 1'b0;
            end
          endcase
          if (!need_fill) begin
            res_d       = make_res(ok, cnt_d, front_d, rear_d, eff_cap);
            res_valid_d = 1'b1;
          end
        end
      end
      ST_FILL: begin
        if (fill_rear_q) begin
          rear_d = rd_data;
        end else begin
          front_d = rd_data;
        end
        res_d       = make_res(1'b1, cnt_q, front_d, rear_d, eff_cap);
        res_valid_d = 1'b1;
      end
      default: begin
        res_valid_d = res_valid_q && !res_fire;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      fill_rear_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      fill_rear_q <= fill_rear_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    rear_q  <= rear_d;
    res_q   <= res_d;
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.ok          = res_q.ok;
  assign res_o.front_value = res_q.front_value;
  assign res_o.rear_value  = res_q.rear_value;
  assign res_o.is_empty    = res_q.is_empty;
  assign res_o.is_full     = res_q.is_full;
  assign res_o.count       = res_q.count;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(Depth))
    else $error("entry count beyond ring depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q) < 32'(Depth))
    else $error("head index outside ring");

  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (res_valid_q || st_q == ST_FILL))
    else $error("accepted item produced neither result nor fetch");

  a_fill_empty_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FILL) |-> (!res_valid_q && !act_i.ready))
    else $error("fetch cycle with result register occupied");

  a_fill_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FILL) |-> (cnt_q != '0))
    else $error("fetch after pop that emptied the deque");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded deque. Result items are predicted by a
// ring-buffer model of the deque and every result item is compared field by
// field; capacity is changed only while the deque is idle, across small,
// zero, saturating and reset-value settings, up to a completely full ring.
// ----------------------------------------------------------------------------
module testbench;
  import bdq_pkg::*;

  localparam logic [ActW-1:0] ActUnknownLo = 3'd5;
  localparam logic [ActW-1:0] ActUnknownHi = 3'd7;
  localparam logic [CapW-1:0] CapTop       = '1;
  localparam logic [DataW-1:0] ValMin      = 32'h8000_0000;
  localparam logic [DataW-1:0] ValMax      = 32'h7FFF_FFFF;

  logic clk_i;
  logic rst_ni;

  bdq_act_if act_if ();
  bdq_res_if res_if ();
  bdq_cfg_if cfg_if ();

  bounded_deque dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .act_i  (act_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // deque model
  logic [DataW-1:0] ring_mem [Depth];
  addr_t            ring_head  = '0;
  cnt_t             ring_count = '0;
  logic [CapW-1:0]  cap_reg    = CapReset;

  res_t due_q [$];
  int   fails    = 0;
  bit   tx_idle  = 1'b1;
  bit   rx_idle  = 1'b1;
  int   hold_req = 0;

  function automatic res_t apply_action(logic [ActW-1:0] act, logic [DataW-1:0] val);
    res_t        r;
    int unsigned lim;
    lim  = (cap_reg > Depth) ? Depth : cap_reg;
    r.ok = 1'b1;
    case (act)
      ACT_QUERY: ;
      ACT_PUSH_FRONT: begin
        if (ring_count >= lim) begin
          r.ok = 1'b0;
        end else begin
          ring_head           = addr_t'((ring_head + Depth - 1) % Depth);
          ring_mem[ring_head] = val;
          ring_count++;
        end
      end
      ACT_PUSH_REAR: begin
        if (ring_count >= lim) begin
          r.ok = 1'b0;
        end else begin
          ring_mem[addr_t'((ring_head + ring_count) % Depth)] = val;
          ring_count++;
        end
      end
      ACT_POP_FRONT: begin
        if (ring_count == 0) begin
          r.ok = 1'b0;
        end else begin
          ring_head = addr_t'((ring_head + 1) % Depth);
          ring_count--;
        end
      end
      ACT_POP_REAR: begin
        if (ring_count == 0) begin
          r.ok = 1'b0;
        end else begin
          ring_count--;
        end
      end
      default: r.ok = 1'b0;
    endcase
    if (ring_count != 0) begin
      r.front_value = ring_mem[ring_head];
      r.rear_value  = ring_mem[addr_t'((ring_head + ring_count - 1) % Depth)];
    end else begin
      r.front_value = EmptyVal;
      r.rear_value  = EmptyVal;
    end
    r.is_empty = (ring_count == 0);
    r.is_full  = (ring_count == lim);
    r.count    = CountW'(ring_count);
    return r;
  endfunction

  // prediction and checking share one process so that same-edge order is fixed
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        cap_reg = cfg_if.capacity;
      end
      if (act_if.valid && act_if.ready) begin
        due_q.push_back(apply_action(act_if.action, act_if.value));
      end
      if (res_if.valid && res_if.ready) begin
        if (due_q.size() == 0) begin
          $error("result item with none expected");
          fails++;
        end else begin
          want = due_q.pop_front();
          if (res_if.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, res_if.ok);
            fails++;
          end
          if (res_if.front_value !== want.front_value) begin
            $error("front_value: expected %0d, got %0d", want.front_value,
                   res_if.front_value);
            fails++;
          end
          if (res_if.rear_value !== want.rear_value) begin
            $error("rear_value: expected %0d, got %0d", want.rear_value,
                   res_if.rear_value);
            fails++;
          end
          if (res_if.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, res_if.is_empty);
            fails++;
          end
          if (res_if.is_full !== want.is_full) begin
            $error("is_full: expected %0d, got %0d", want.is_full, res_if.is_full);
            fails++;
          end
          if (res_if.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, res_if.count);
            fails++;
          end
        end
      end
    end
  end

  // result receiver: random stalls, plus long hold-offs on request
  initial begin
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (hold_req > 0) begin
        res_if.ready <= 1'b0;
        stall_left = hold_req - 1;
        hold_req   = 0;
      end else if (rx_idle && $urandom_range(0, 99) < 30) begin
        res_if.ready <= 1'b0;
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(7, 39);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!tx_idle || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ActW-1:0] pick_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return ACT_QUERY;
    end else if (r < 29) begin
      return ACT_PUSH_FRONT;
    end else if (r < 50) begin
      return ACT_PUSH_REAR;
    end else if (r < 70) begin
      return ACT_POP_FRONT;
    end else if (r < 90) begin
      return ACT_POP_REAR;
    end
    return ActW'($urandom_range(ActUnknownLo, ActUnknownHi));
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return ValMin;
    end else if (r < 20) begin
      return ValMax;
    end else if (r < 28) begin
      return EmptyVal;
    end else if (r < 33) begin
      return '0;
    end
    return $urandom;
  endfunction

  // valid stays high after a handshake so that back-to-back items need no toggle
  task automatic send_action(logic [ActW-1:0] act, logic [DataW-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      act_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    act_if.valid  <= 1'b1;
    act_if.action <= act;
    act_if.value  <= val;
    do @(posedge clk_i); while (!act_if.ready);
  endtask

  task automatic wait_drained();
    act_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_q.size() != 0);
  endtask

  task automatic write_capacity(logic [CapW-1:0] cap);
    wait_drained();
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= cap;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_directed();
    // empty deque at reset capacity
    send_action(ACT_QUERY, '0);
    send_action(ACT_POP_FRONT, '0);
    send_action(ACT_POP_REAR, ValMax);
    send_action(ActUnknownLo, ValMin);
    send_action(ACT_PUSH_REAR, ValMax);
    send_action(ACT_PUSH_FRONT, ValMin);
    send_action(ACT_PUSH_REAR, EmptyVal);
    send_action(ACT_PUSH_FRONT, '0);
    send_action(ActUnknownHi, ValMax);
    send_action(ACT_POP_FRONT, '0);
    send_action(ACT_POP_REAR, '0);
    // capacity lowered below the count
    write_capacity(CapW'(1));
    send_action(ACT_PUSH_REAR, 32'h1234_5678);
    send_action(ACT_POP_FRONT, '0);
    send_action(ACT_POP_REAR, '0);
    // zero capacity: empty and full together
    write_capacity('0);
    send_action(ACT_QUERY, '0);
    send_action(ACT_PUSH_FRONT, ValMax);
    send_action(ActW'(ActUnknownLo + 1), '0);
    // capacity above the ring depth
    write_capacity(CapTop);
    send_action(ACT_PUSH_REAR, 32'hA5A5_5A5A);
    send_action(ACT_POP_FRONT, '0);
    wait_drained();
  endtask

  task automatic test_mixed();
    logic [CapW-1:0] caps [6];
    caps = '{CapW'(12), CapW'(3), CapW'(0), CapW'(1), CapW'(2), CapW'(5)};
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      tx_idle = (p != 2);
      rx_idle = (p != 2);
      repeat (10) send_action(pick_action(), pick_value());
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 60;
    repeat (12) send_action(pick_action(), pick_value());
    // sender holds back until every result is in
    wait_drained();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (8) send_action(pick_action(), pick_value());
    wait_drained();
  endtask

  task automatic test_fill();
    int unsigned r;
    write_capacity(CapTop);
    while (ring_count < Depth) begin
      r = $urandom_range(0, 99);
      if (r < 48) begin
        send_action(ACT_PUSH_FRONT, pick_value());
      end else if (r < 96) begin
        send_action(ACT_PUSH_REAR, pick_value());
      end else begin
        send_action(pick_action(), pick_value());
      end
    end
    repeat (2) send_action(ACT_PUSH_FRONT, pick_value());
    repeat (2) send_action(ACT_PUSH_REAR, pick_value());
    send_action(ACT_QUERY, '0);
    write_capacity(CapReset);
    send_action(ACT_QUERY, '0);
    send_action(ACT_POP_FRONT, '0);
    send_action(ACT_PUSH_FRONT, ValMin);
    send_action(ACT_PUSH_REAR, ValMax);
    write_capacity(CapW'(2));
    repeat (3) send_action(ACT_POP_REAR, '0);
    send_action(ACT_PUSH_REAR, pick_value());
    repeat (20) send_action(pick_action(), pick_value());
    wait_drained();
  endtask

  initial begin
    rst_ni          <= 1'b0;
    act_if.valid    <= 1'b0;
    act_if.action   <= ACT_QUERY;
    act_if.value    <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.capacity <= CapReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_mixed();
    test_backpressure();
    test_fill();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: bounded_deque.f
sv/bdq_pkg.sv
sv/bdq_if.sv
sv/bdq_mem.sv
sv/bounded_deque.sv
verif/testbench.sv
